// File: rtl/mseu_pkg.sv
// Package: shared constants and types for the USB-MIDI event packet encoder
`default_nettype none

package mseu_pkg;

    // MIDI status bytes of interest
    localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
    localparam logic [7:0] MIDI_MTC_QF      = 8'hF1;
    localparam logic [7:0] MIDI_SONG_POS    = 8'hF2;
    localparam logic [7:0] MIDI_SONG_SEL    = 8'hF3;
    localparam logic [7:0] MIDI_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
    localparam logic [7:0] MIDI_REALTIME_LO = 8'hF8;
    localparam logic [7:0] MIDI_STATUS_LO   = 8'h80;
    localparam logic [3:0] MIDI_HI_PROG     = 4'hC;
    localparam logic [3:0] MIDI_HI_CHPRESS  = 4'hD;
    localparam logic [3:0] MIDI_HI_SYSTEM   = 4'hF;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_NONE     = 4'h0;
    localparam logic [3:0] CIN_SC2      = 4'h2;
    localparam logic [3:0] CIN_SC3      = 4'h3;
    localparam logic [3:0] CIN_SX_START = 4'h4;
    localparam logic [3:0] CIN_SX_END1  = 4'h5;
    localparam logic [3:0] CIN_SX_END2  = 4'h6;
    localparam logic [3:0] CIN_SX_END3  = 4'h7;
    localparam logic [3:0] CIN_SINGLE   = 4'hF;

    // Packet produced by the encoder core for one input word
    typedef struct packed {
        logic       valid;
        logic [3:0] code_index;
        logic [7:0] midi_first;
        logic [7:0] midi_second;
        logic [7:0] midi_third;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/mseu_if.sv
// Interfaces: valid/ready channels for MIDI byte words and USB-MIDI packet words
`default_nettype none

interface mseu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mseu_pkt_if;
    logic       valid;
    logic       ready;
    logic [3:0] code_index;
    logic [3:0] cable;
    logic [7:0] midi_first;
    logic [7:0] midi_second;
    logic [7:0] midi_third;

    modport source (output valid, output code_index, output cable, output midi_first,
                    output midi_second, output midi_third, input ready);
    modport sink   (input valid, input code_index, input cable, input midi_first,
                    input midi_second, input midi_third, output ready);
endinterface

`default_nettype wire

// File: rtl/mseu_core.sv
// Encoder core: message parsing state and packet formation for one MIDI byte
`default_nettype none

module mseu_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last_byte,
    output mseu_pkg::t_result     o_res
);
    import mseu_pkg::*;

    logic       r_in_sysex, n_in_sysex;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_held_count, n_held_count;
    logic [1:0] r_need, n_need;
    logic [3:0] r_pend_code, n_pend_code;
    t_result    res;

    // Work out the packet and the next parser state for the incoming word
    always_comb begin
        logic [7:0] b;
        b = i_data_byte;

        n_in_sysex   = r_in_sysex;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_held_count = r_held_count;
        n_need       = r_need;
        n_pend_code  = r_pend_code;

        res.valid       = 1'b0;
        res.code_index  = CIN_NONE;
        res.midi_first  = 8'h00;
        res.midi_second = 8'h00;
        res.midi_third  = 8'h00;

        if (r_need != 2'd0) begin
            // Gather data of a pending message, whatever the byte value
            if (r_need == 2'd1) begin
                res.valid      = 1'b1;
                res.code_index = r_pend_code;
                res.midi_first = r_held0;
                if (r_held_count >= 2'd2) begin
                    res.midi_second = r_held1;
                    res.midi_third  = b;
                end else begin
                    res.midi_second = b;
                end
                n_held_count = 2'd0;
                n_need       = 2'd0;
                n_pend_code  = CIN_NONE;
            end else begin
                if (r_held_count < 2'd2) begin
                    if (r_held_count[0]) n_held1 = b;
                    else                 n_held0 = b;
                    n_held_count = r_held_count + 2'd1;
                end
                n_need = r_need - 2'd1;
            end
        end else if (b == MIDI_SYSEX_START) begin
            // Start (or restart) SysEx with the F0 held
            n_in_sysex   = 1'b1;
            n_held0      = MIDI_SYSEX_START;
            n_held_count = 2'd1;
        end else if (r_in_sysex) begin
            if (b == MIDI_SYSEX_END) begin
                // Close SysEx with an end packet of one to three bytes
                res.valid = 1'b1;
                case (r_held_count)
                    2'd0: begin
                        res.code_index = CIN_SX_END1;
                        res.midi_first = MIDI_SYSEX_END;
                    end
                    2'd1: begin
                        res.code_index  = CIN_SX_END2;
                        res.midi_first  = r_held0;
                        res.midi_second = MIDI_SYSEX_END;
                    end
                    default: begin
                        res.code_index  = CIN_SX_END3;
                        res.midi_first  = r_held0;
                        res.midi_second = r_held1;
                        res.midi_third  = MIDI_SYSEX_END;
                    end
                endcase
                n_in_sysex   = 1'b0;
                n_held_count = 2'd0;
            end else if (b >= MIDI_STATUS_LO) begin
                // Pass an interleaved status through on its own
                res.valid      = 1'b1;
                res.code_index = CIN_SINGLE;
                res.midi_first = b;
            end else if (r_held_count >= 2'd2) begin
                // Flush three SysEx bytes as a start packet
                res.valid       = 1'b1;
                res.code_index  = CIN_SX_START;
                res.midi_first  = r_held0;
                res.midi_second = r_held1;
                res.midi_third  = b;
                n_held_count    = 2'd0;
            end else begin
                if (r_held_count[0]) n_held1 = b;
                else                 n_held0 = b;
                n_held_count = r_held_count + 2'd1;
            end
        end else if (b >= MIDI_REALTIME_LO) begin
            // Send real-time bytes at once
            res.valid      = 1'b1;
            res.code_index = CIN_SINGLE;
            res.midi_first = b;
        end else if (b[7:4] == MIDI_HI_SYSTEM) begin
            // System common: size from status, drop undefined codes
            case (b)
                MIDI_MTC_QF, MIDI_SONG_SEL: begin
                    n_held0      = b;
                    n_held_count = 2'd1;
                    n_need       = 2'd1;
                    n_pend_code  = CIN_SC2;
                end
                MIDI_SONG_POS: begin
                    n_held0      = b;
                    n_held_count = 2'd1;
                    n_need       = 2'd2;
                    n_pend_code  = CIN_SC3;
                end
                MIDI_TUNE_REQ, MIDI_SYSEX_END: begin
                    res.valid      = 1'b1;
                    res.code_index = CIN_SX_END1;
                    res.midi_first = b;
                end
                default: begin
                end
            endcase
        end else if (b[7]) begin
            // Channel message: two bytes for program change and pressure
            n_held0      = b;
            n_held_count = 2'd1;
            n_pend_code  = b[7:4];
            if (b[7:4] == MIDI_HI_PROG || b[7:4] == MIDI_HI_CHPRESS) n_need = 2'd1;
            else                                                      n_need = 2'd2;
        end

        // Drop any unfinished message after the last word of a buffer
        if (i_last_byte) begin
            n_in_sysex   = 1'b0;
            n_held_count = 2'd0;
            n_need       = 2'd0;
            n_pend_code  = CIN_NONE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sysex   <= 1'b0;
            r_held_count <= 2'd0;
            r_need       <= 2'd0;
            r_pend_code  <= CIN_NONE;
        end else if (i_take) begin
            r_in_sysex   <= n_in_sysex;
            r_held_count <= n_held_count;
            r_need       <= n_need;
            r_pend_code  <= n_pend_code;
        end
    end

    // Held message bytes
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

    assign o_res = res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3)
        else $error("held byte count out of range");

    a_gather_outside_sysex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 2'd0) |-> (!r_in_sysex && r_held_count != 2'd0 &&
                              r_pend_code != CIN_NONE))
        else $error("pending message state inconsistent");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_byte) |=> (!r_in_sysex && r_held_count == 2'd0 &&
                                     r_need == 2'd0))
        else $error("state not cleared after last word");

endmodule

`default_nettype wire

// File: rtl/midi_stream_to_usb_event_packets.sv
// Top level: MIDI byte stream to USB-MIDI event packet encoder
//
// Usage:
//   i_byte takes one MIDI byte word per cycle (valid/ready); last_byte marks the
//   final byte of a buffer, after which any unfinished message is dropped.
//   o_pkt gives one USB-MIDI event packet word: code index, cable and three
//   MIDI bytes, unused bytes zero. A byte yields zero or one packet.
//   i_cfg_we / i_cfg_wdata load the cable number; write it only while idle.
// Timing:
//   One byte is taken per cycle unless the sink stalls. The packet completed by
//   a byte is on o_pkt in the cycle after it is accepted, from a single output
//   register. The input stays ready while that register is empty or is being
//   drained in the same cycle, so a byte may be accepted while a packet waits.
// Reset:
//   Synchronous, active low: parser state clears, output empties, cable is 0.
// Stall:
//   While the sink holds ready low with a packet waiting, the input is held
//   off and the waiting packet stays unchanged.
`default_nettype none

module midi_stream_to_usb_event_packets (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    mseu_byte_if.sink       i_byte,
    mseu_pkt_if.source      o_pkt
);
    import mseu_pkg::*;

    logic       r_cable;
    logic [3:0] r_cable_nr;
    logic       r_out_valid;
    logic [3:0] r_out_code;
    logic [3:0] r_out_cable;
    logic [7:0] r_out_first;
    logic [7:0] r_out_second;
    logic [7:0] r_out_third;
    logic       take;
    t_result    res;

    // Accept a word while the output register is free or draining
    assign i_byte.ready = !r_out_valid || o_pkt.ready;
    assign take         = i_byte.valid && i_byte.ready;

    mseu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_byte.data_byte),
        .i_last_byte (i_byte.last_byte),
        .o_res       (res)
    );

    // Cable number register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable_nr <= 4'd0;
            r_cable    <= 1'b0;
        end else if (i_cfg_we) begin
            r_cable_nr <= i_cfg_wdata;
            r_cable    <= 1'b1;
        end
    end

    // Output word valid: load on a new packet, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_out_code   <= res.code_index;
            r_out_cable  <= r_cable_nr;
            r_out_first  <= res.midi_first;
            r_out_second <= res.midi_second;
            r_out_third  <= res.midi_third;
        end
    end

    assign o_pkt.valid       = r_out_valid;
    assign o_pkt.code_index  = r_out_code;
    assign o_pkt.cable       = r_out_cable;
    assign o_pkt.midi_first  = r_out_first;
    assign o_pkt.midi_second = r_out_second;
    assign o_pkt.midi_third  = r_out_third;

    a_packet_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && res.valid) |=> (o_pkt.valid && o_pkt.code_index == $past(res.code_index)))
        else $error("completed packet not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pkt.ready) |-> !take)
        else $error("word accepted over a stalled packet");

    a_cable_tracks_config: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && res.valid && r_cable) |=> (o_pkt.cable == $past(r_cable_nr)))
        else $error("packet cable differs from configured cable");

endmodule

`default_nettype wire
